// ===== src/nta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number formatter package
// Shared constants, types and helpers for the number-to-ASCII formatter.
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int VALUE_BITS  = 16;
  localparam int BCD_DIGITS  = 5;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int HEX_NIBBLES = (VALUE_BITS + 3) / 4;
  localparam int HEX_CAP     = (HEX_NIBBLES > 6) ? 6 : HEX_NIBBLES;
  localparam int RUN_MAX     = 7;
  localparam int RUN_W       = 3;
  localparam int STEP_W      = $clog2(VALUE_BITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_SDEC = 2'd1,
    MODE_UDEC = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_RAW = 2'd0,
    KIND_DEC = 2'd1,
    KIND_HEX = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic                   neg;
    logic [VALUE_BITS-1:0]  mag;
    logic [2:0]             hex_cnt;
    logic                   nl;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CHAR_ZERO + {4'b0000, nib};
    end else begin
      return CHAR_A + {4'b0000, nib} - 8'd10;
    end
  endfunction

endpackage

// ===== src/number_to_ascii_formatter_core.sv =====
`timescale 1ns / 1ps
// A raw or hex request passes from the front queue through the idle, load and
// emit states; a decimal request also waits on the 16-step BCD converter.
// Throughput: one character per cycle while emitting, unless the result queue
// is full; a new request is taken only once the last one is fully queued.
// Reset is asynchronous, active low, and empties both queues and the sequencer.
// ----------------------------------------------------------------------------
// Number to ASCII formatter
// Front end queues classified requests; back end converts and emits the
// characters of each request, marking the last one.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [15:0] value_i,
  input  logic [2:0]  hex_digits_i,
  input  logic        add_newline_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  ascii_char_o,
  output logic        last_char_o
);
  import nta_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  nta_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .hex_digits_i  (hex_digits_i),
    .add_newline_i (add_newline_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  nta_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

// ===== src/nta_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts requests, classifies them into commands and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module nta_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    mode_i,
  input  logic [15:0]   value_i,
  input  logic [2:0]    hex_digits_i,
  input  logic          add_newline_i,
  output logic          cmd_valid_o,
  output nta_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import nta_pkg::*;

  cmd_t                  q_mem [2];
  logic                  wr_q, wr_d, rd_q, rd_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;
  cmd_t                  cls;
  logic [VALUE_BITS-1:0] v;
  mode_e                 mode;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  assign v    = value_i[VALUE_BITS-1:0];
  assign mode = mode_e'(mode_i);

  always_comb begin
    cls.kind    = KIND_RAW;
    cls.neg     = 1'b0;
    cls.mag     = v;
    cls.hex_cnt = (hex_digits_i > 3'(HEX_CAP)) ? 3'(HEX_CAP) : hex_digits_i;
    cls.nl      = add_newline_i;
    unique case (mode)
      MODE_RAW:  cls.kind = KIND_RAW;
      MODE_SDEC: begin
        cls.kind = KIND_DEC;
        if (v[VALUE_BITS-1]) begin
          cls.neg = 1'b1;
          cls.mag = ~v + 1'b1;
        end
      end
      MODE_UDEC: cls.kind = KIND_DEC;
      MODE_HEX:  cls.kind = KIND_HEX;
      default:   cls.kind = KIND_RAW;
    endcase
  end

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= cls;
    end
  end

endmodule

// ===== src/nta_bcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-three conversion, one input bit per cycle.
// ----------------------------------------------------------------------------
module nta_bcd (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [nta_pkg::VALUE_BITS-1:0]       bin_i,
  output logic                                 done_o,
  output logic [nta_pkg::BCD_W-1:0]            bcd_o
);
  import nta_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     cnt_q;
  logic [VALUE_BITS-1:0] bin_q;
  logic [BCD_W-1:0]      bcd_q;
  logic [BCD_W-1:0]      adj;

  // Any digit of five or more is corrected before the shift doubles it.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                 : bcd_q[4*i +: 4];
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= STEP_W'(VALUE_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== src/nta_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter back end
// Takes commands from the front queue, converts decimal values, builds the
// character run and sends it out through a two-entry result queue.
// ----------------------------------------------------------------------------
module nta_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  nta_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    ascii_char_o,
  output logic          last_char_o
);
  import nta_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state_q, state_d;
  cmd_t             cmd_q;
  logic [RUN_W-1:0] pos_q, pos_d;
  logic [RUN_W-1:0] n_q;
  logic [7:0]       buf_q [RUN_MAX];

  logic             bcd_start;
  logic             bcd_done;
  logic [BCD_W-1:0] bcd;

  logic [3:0]       dig [BCD_DIGITS];
  logic [RUN_W-1:0] lead;
  logic [RUN_W-1:0] ndig;
  logic [RUN_W-1:0] negw;
  logic [RUN_W-1:0] body;
  logic [RUN_W-1:0] load_n;
  logic [7:0]       load_buf [RUN_MAX];

  logic [8:0]       oq_mem [2];
  logic             oq_wr_q, oq_rd_q;
  logic [1:0]       oq_cnt_q;
  logic             oq_push;
  logic             oq_pop;
  logic             emit_last;

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign bcd_start = cmd_pop_o && (cmd_i.kind == KIND_DEC);

  nta_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .bin_i   (cmd_i.mag),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  // Digits most significant first; leading zeros are skipped but the
  // last digit always stays so that zero prints as a single '0'.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      dig[i] = bcd[4*(BCD_DIGITS-1-i) +: 4];
    end
    priority if (dig[0] != 4'd0) lead = 3'd0;
    else if (dig[1] != 4'd0)     lead = 3'd1;
    else if (dig[2] != 4'd0)     lead = 3'd2;
    else if (dig[3] != 4'd0)     lead = 3'd3;
    else                         lead = 3'd4;
  end

  assign ndig = RUN_W'(BCD_DIGITS) - lead;
  assign negw = {2'b00, cmd_q.neg};

  always_comb begin
    unique case (cmd_q.kind)
      KIND_RAW: body = 3'd1;
      KIND_DEC: body = negw + ndig;
      KIND_HEX: body = cmd_q.hex_cnt;
      default:  body = 3'd0;
    endcase
  end

  assign load_n = body + {2'b00, cmd_q.nl};

  always_comb begin
    logic [RUN_W-1:0] pp;
    logic [RUN_W-1:0] k;
    logic [RUN_W-1:0] idx;
    for (int p = 0; p < RUN_MAX; p++) begin
      pp  = RUN_W'(p);
      k   = lead + pp - negw;
      idx = cmd_q.hex_cnt - 3'd1 - pp;
      load_buf[p] = CHAR_NL;
      if (pp < body) begin
        unique case (cmd_q.kind)
          KIND_RAW: load_buf[p] = cmd_q.mag[7:0];
          KIND_DEC: begin
            if (pp < negw) begin
              load_buf[p] = CHAR_MINUS;
            end else begin
              load_buf[p] = CHAR_ZERO + {4'b0000, dig[k]};
            end
          end
          KIND_HEX: load_buf[p] = hex_char(cmd_q.mag[{idx[1:0], 2'b00} +: 4]);
          default:  load_buf[p] = CHAR_NL;
        endcase
      end
    end
  end

  assign emit_last = (pos_q == n_q - 3'd1);
  assign oq_push   = (state_q == S_EMIT) && (oq_cnt_q != 2'd2);
  assign oq_pop    = pop && !empty;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.kind == KIND_DEC) ? S_CONV : S_LOAD;
        end
      end
      S_CONV: begin
        if (bcd_done) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        pos_d   = '0;
        // A hex request of no digits and no newline yields nothing.
        state_d = (load_n == 3'd0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (oq_push) begin
          pos_d = pos_q + 1'b1;
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= '0;
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      oq_wr_q  <= oq_push ? ~oq_wr_q : oq_wr_q;
      oq_rd_q  <= oq_pop ? ~oq_rd_q : oq_rd_q;
      oq_cnt_q <= oq_cnt_q + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_LOAD) begin
      n_q <= load_n;
      for (int p = 0; p < RUN_MAX; p++) begin
        buf_q[p] <= load_buf[p];
      end
    end
    if (oq_push) begin
      oq_mem[oq_wr_q] <= {emit_last, buf_q[pos_q]};
    end
  end

  assign empty        = (oq_cnt_q == 2'd0);
  assign ascii_char_o = oq_mem[oq_rd_q][7:0];
  assign last_char_o  = oq_mem[oq_rd_q][8];

endmodule

// ===== tb/sv/nta_char_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character stream checker
// Watches the request and character queues of the formatter, works out the
// characters each accepted request must produce and compares every popped
// character, field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module nta_char_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [1:0]  mode_i,
  input  logic [15:0] value_i,
  input  logic [2:0]  hex_digits_i,
  input  logic        add_newline_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  ascii_char_i,
  input  logic        last_char_i,
  output int          fail_count_o,
  output int          pending_o
);
  import nta_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  char_t char_q[$];
  char_t head;
  int    err_cnt;

  // Appends the characters that one request must produce to the queue.
  function automatic void format_request(input logic [1:0]  m,
                                         input logic [15:0] v_in,
                                         input logic [2:0]  d,
                                         input logic        nl);
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            nib;
    logic [7:0]            run[$];
    logic [7:0]            digs[$];
    int                    cnt;
    v = VALUE_BITS'(v_in);
    case (mode_e'(m))
      MODE_RAW: begin
        run.push_back(v[7:0]);
      end
      MODE_SDEC, MODE_UDEC: begin
        mag = v;
        if (mode_e'(m) == MODE_SDEC && v[VALUE_BITS-1]) begin
          run.push_back(CHAR_MINUS);
          // The magnitude of the most negative value still fits unsigned.
          mag = -v;
        end
        do begin
          digs.push_front(CHAR_ZERO + 8'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
        run = {run, digs};
      end
      default: begin
        cnt = (int'(d) > HEX_CAP) ? HEX_CAP : int'(d);
        for (int i = cnt - 1; i >= 0; i--) begin
          nib = 4'(v >> (4 * i));
          run.push_back((nib < 4'd10) ? CHAR_ZERO + 8'(nib) : CHAR_A + 8'(nib) - 8'd10);
        end
      end
    endcase
    if (nl) begin
      run.push_back(CHAR_NL);
    end
    foreach (run[i]) begin
      char_q.push_back('{ch: run[i], last: (i == run.size() - 1)});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q.delete();
      err_cnt = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (char_q.size() == 0) begin
          $error("unexpected character: ascii_char %h, last_char %b",
                 ascii_char_i, last_char_i);
          err_cnt++;
        end else begin
          head = char_q.pop_front();
          if (ascii_char_i !== head.ch) begin
            $error("ascii_char: expected %h, actual %h", head.ch, ascii_char_i);
            err_cnt++;
          end
          if (last_char_i !== head.last) begin
            $error("last_char: expected %b, actual %b", head.last, last_char_i);
            err_cnt++;
          end
        end
      end
      if (push_i && !full_i) begin
        format_request(mode_i, value_i, hex_digits_i, add_newline_i);
      end
      fail_count_o <= err_cnt;
      pending_o <= char_q.size();
    end
  end

endmodule

// ===== tb/sv/number_to_ascii_formatter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Number to ASCII formatter testbench
// Sends directed and random formatting requests in bursts while the
// character side stalls in changing patterns; a checker alongside the block
// predicts and compares every character.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_core_tb;
  import nta_pkg::*;

  localparam int RUN_LIMIT    = 500000;
  localparam int RANDOM_ITEMS = 420;
  localparam int DRAIN_CYCLES = 60;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        push          = 1'b0;
  logic        full;
  logic [1:0]  mode          = '0;
  logic [15:0] value         = '0;
  logic [2:0]  hex_digits    = '0;
  logic        add_newline   = 1'b0;
  logic        empty;
  logic        pop           = 1'b0;
  logic [7:0]  ascii_char;
  logic        last_char;

  int fail_count;
  int pending;
  int cycles      = 0;
  int burst_left  = 0;
  int stall_pct   = 0;
  int stall_left  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  number_to_ascii_formatter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode),
    .value_i       (value),
    .hex_digits_i  (hex_digits),
    .add_newline_i (add_newline),
    .empty         (empty),
    .pop           (pop),
    .ascii_char_o  (ascii_char),
    .last_char_o   (last_char)
  );

  nta_char_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .mode_i        (mode),
    .value_i       (value),
    .hex_digits_i  (hex_digits),
    .add_newline_i (add_newline),
    .empty_i       (empty),
    .pop_i         (pop),
    .ascii_char_i  (ascii_char),
    .last_char_i   (last_char),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("number_to_ascii_formatter_core_tb failed");
      $finish;
    end
  end

  // The character side changes its stall rate every so often, from never
  // stalling to stalling almost always.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        2:       stall_pct = 65;
        default: stall_pct = 92;
      endcase
      stall_left = $urandom_range(60, 250);
    end else begin
      stall_left--;
    end
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Presents one request, holds it until accepted, then closes the burst
  // with a random gap, at times none, when the burst is used up.
  task automatic request(input logic [1:0] m, input logic [15:0] v,
                         input logic [2:0] d, input logic nl);
    int gap;
    push <= 1'b1;
    mode <= m;
    value <= v;
    hex_digits <= d;
    add_newline <= nl;
    do @(posedge clk_i); while (full);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [15:0] v;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    request(MODE_RAW,  16'h0000, 3'd0, 1'b0);
    request(MODE_RAW,  16'hFFFF, 3'd7, 1'b1);
    request(MODE_RAW,  16'h1241, 3'd2, 1'b0);
    request(MODE_SDEC, 16'h0000, 3'd0, 1'b0);
    request(MODE_SDEC, 16'h7FFF, 3'd0, 1'b1);
    request(MODE_SDEC, 16'h8000, 3'd0, 1'b0);
    request(MODE_SDEC, 16'hFFFF, 3'd0, 1'b1);
    request(MODE_SDEC, 16'hCFC7, 3'd0, 1'b0);
    request(MODE_SDEC, 16'h0001, 3'd0, 1'b0);
    request(MODE_UDEC, 16'h0000, 3'd0, 1'b1);
    request(MODE_UDEC, 16'hFFFF, 3'd0, 1'b0);
    request(MODE_UDEC, 16'h0009, 3'd0, 1'b0);
    request(MODE_UDEC, 16'h000A, 3'd0, 1'b1);
    request(MODE_UDEC, 16'h8000, 3'd0, 1'b0);
    // No digits and no newline: the request leaves no characters at all.
    request(MODE_HEX,  16'h1234, 3'd0, 1'b0);
    request(MODE_HEX,  16'h1234, 3'd0, 1'b1);
    request(MODE_HEX,  16'hABCD, 3'd1, 1'b0);
    request(MODE_HEX,  16'h0000, 3'd4, 1'b1);
    request(MODE_HEX,  16'hFFFF, 3'd4, 1'b0);
    request(MODE_HEX,  16'h1234, 3'd5, 1'b1);
    request(MODE_HEX,  16'hFEDC, 3'd7, 1'b0);
    request(MODE_HEX,  16'h5A6F, 3'd3, 1'b0);
    request(MODE_HEX,  16'h00C3, 3'd2, 1'b1);
    request(MODE_HEX,  16'h89AB, 3'd6, 1'b1);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 5))
        0, 1:    v = 16'($urandom_range(0, 65535));
        2:       v = 16'($urandom_range(0, 20));
        3:       v = 16'h7FFC + 16'($urandom_range(0, 7));
        4:       v = 16'hFFFF - 16'($urandom_range(0, 20));
        default: begin
          case ($urandom_range(0, 3))
            0:       v = 16'd10;
            1:       v = 16'd100;
            2:       v = 16'd1000;
            default: v = 16'd10000;
          endcase
          v = v - 16'($urandom_range(0, 1));
        end
      endcase
      request(2'($urandom_range(0, 3)), v, 3'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)));
      if (i == RANDOM_ITEMS / 2) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("number_to_ascii_formatter_core_tb passed");
    end else begin
      $display("number_to_ascii_formatter_core_tb failed");
    end
    $finish;
  end

endmodule
